>>> rtl/tcf_pkg.sv
// Package for the tilt complementary filter.
// Holds widths, register indexes, sequencer states, unit request and response types and the angle table.
// Depends on nothing.
package tcf_pkg;

  localparam int IN_W            = 16;
  localparam int ANG_W           = 24;
  localparam int ANGQ_W          = 22;
  localparam int AXIS_W          = 22;
  localparam int GN_W            = 26;
  localparam int ASUM_W          = 20;
  localparam int GSUM_W          = 24;
  localparam int WIDE_W          = 64;
  localparam int ACC_W           = 32;
  localparam int OPND_W          = 33;
  localparam int CNT_W           = 6;
  localparam int RAW_SHIFT       = 4;
  localparam int CORDIC_ITERS    = 24;
  localparam int SQRT_ITERS      = 32;
  localparam int GAIN_W          = 17;
  localparam int STEP_W          = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CAL_SAMPLES_DEF = 256;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd64225;
  localparam logic [STEP_W-1:0] STEP_RESET = 32'd46976;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN  = 2'd2;

  // 180 degrees at 2^20 per degree
  localparam logic signed [ACC_W-1:0] ANG_180 = 32'sd188743680;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CORDIC,
    OP_SQRT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROLL_INIT,
    ST_CORDIC,
    ST_CORDIC_END,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_PITCH_INIT,
    ST_GYRO_MUL,
    ST_GYRO_SCALE,
    ST_GYRO_DIV,
    ST_GYRO_END,
    ST_BLEND_PREV,
    ST_BLEND_ACC,
    ST_BLEND_SUM,
    ST_BLEND_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic [WIDE_W-1:0]        p;
    logic [WIDE_W-1:0]        q;
    logic signed [ACC_W-1:0]  r;
    logic [CNT_W-1:0]         cnt;
    logic signed [OPND_W-1:0] ma;
    logic signed [OPND_W-1:0] mb;
  } iter_req_t;

  typedef struct packed {
    logic [WIDE_W-1:0]        p;
    logic [WIDE_W-1:0]        q;
    logic signed [ACC_W-1:0]  r;
    logic signed [WIDE_W-1:0] prod;
  } iter_rsp_t;

  function automatic int trailing_zeros(input int v);
    int   n;
    logic found;
    n     = 0;
    found = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (!found && v[i]) begin
        found = 1'b1;
      end else if (!found) begin
        n++;
      end
    end
    return n;
  endfunction

  // round(atan(2^-i) * 180 / pi * 2^20)
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      5'd20:   v = 32'sd57;
      5'd21:   v = 32'sd29;
      5'd22:   v = 32'sd14;
      5'd23:   v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/tcf_iter.sv
// Shared iteration unit: one CORDIC or square-root step, plus the multiplier.
// Purely combinational; the sequencer holds all operands in registers.
// Depends on tcf_pkg.
module tcf_iter (
  input  tcf_pkg::iter_req_t req,
  output tcf_pkg::iter_rsp_t rsp
);
  import tcf_pkg::*;

  logic signed [WIDE_W-1:0]   x;
  logic signed [WIDE_W-1:0]   y;
  logic signed [WIDE_W-1:0]   xs;
  logic signed [WIDE_W-1:0]   ys;
  logic [WIDE_W-1:0]          bitv;
  logic [WIDE_W-1:0]          trial;
  logic signed [2*OPND_W-1:0] full;

  always_comb begin
    x     = $signed(req.p);
    y     = $signed(req.q);
    xs    = x >>> req.cnt;
    ys    = y >>> req.cnt;
    bitv  = WIDE_W'(1) << {req.cnt, 1'b0};
    trial = req.q + bitv;
    full  = req.ma * req.mb;

    rsp.p    = req.p;
    rsp.q    = req.q;
    rsp.r    = req.r;
    rsp.prod = full[WIDE_W-1:0];

    unique case (req.op)
      OP_CORDIC: begin
        if (!y[WIDE_W-1]) begin
          rsp.p = x + ys;
          rsp.q = y - xs;
          rsp.r = req.r + atan_entry(req.cnt[4:0]);
        end else begin
          rsp.p = x - ys;
          rsp.q = y + xs;
          rsp.r = req.r - atan_entry(req.cnt[4:0]);
        end
      end
      OP_SQRT: begin
        if (req.p >= trial) begin
          rsp.p = req.p - trial;
          rsp.q = (req.q >> 1) + bitv;
        end else begin
          rsp.q = req.q >> 1;
        end
      end
      OP_HOLD: begin
        rsp.p = req.p;
      end
      default: begin
        rsp.p = req.p;
      end
    endcase
  end

endmodule

>>> rtl/tilt_complementary_filter.sv
// Top level of the tilt complementary filter: sequencer, state and configuration registers.
// Roll and pitch from accelerometer and gyro through one shared iteration unit.
// Depends on tcf_pkg and tcf_iter.
//
//   channel | handshake             | contents
//   --------+-----------------------+---------------------------------------------
//   in      | in_valid / in_stall   | accel_x/y/z_raw, gyro_x/y_raw
//   out     | out_valid / out_stall | roll_angle, pitch_angle (Q11.12 degrees)
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The first CAL_SAMPLES requests are taken one a cycle and give no result.
// A later request runs two 24-step CORDIC passes and a 32-step square root on the shared
// unit, plus multiplies and the blend.
// When CAL_SAMPLES is not a power of two each gyro term also goes through a division: the odd part of
// the divisor is taken off one 16-bit digit at a time by reciprocal multiply and remainder.
// Synchronous reset; a result held under out_stall does not block the next request.
module tilt_complementary_filter #(
  parameter int CAL_SAMPLES = tcf_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tcf_pkg::IN_W-1:0]     accel_x_raw,
  input  logic signed [tcf_pkg::IN_W-1:0]     accel_y_raw,
  input  logic signed [tcf_pkg::IN_W-1:0]     accel_z_raw,
  input  logic signed [tcf_pkg::IN_W-1:0]     gyro_x_raw,
  input  logic signed [tcf_pkg::IN_W-1:0]     gyro_y_raw,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tcf_pkg::ANG_W-1:0]    roll_angle,
  output logic signed [tcf_pkg::ANG_W-1:0]    pitch_angle,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcf_pkg::STEP_W-1:0]          cfg_data
);
  import tcf_pkg::*;

  localparam int     CALC_W     = $clog2(CAL_SAMPLES + 1);
  localparam int     TZ         = trailing_zeros(CAL_SAMPLES);
  localparam int     ODD        = CAL_SAMPLES >> TZ;
  localparam int     GSHIFT     = RAW_SHIFT + TZ;
  localparam int     HALF_DIV   = 8 * CAL_SAMPLES;
  localparam int     DIV_DIGITS = WIDE_W / 16;
  // ceil(2^32 / ODD), exact for 24-bit partial dividends
  localparam longint RECIP      = (ODD > 1) ? 64'sd4294967296 / ODD + 1 : 64'sd0;

  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(8388607);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -WIDE_W'(8388608);

  state_t state, state_next;

  logic [CALC_W-1:0]         calib_count;
  logic signed [ASUM_W-1:0]  asum [3];
  logic signed [GSUM_W-1:0]  gsum [2];
  logic signed [ANG_W-1:0]   roll_state;
  logic signed [ANG_W-1:0]   pitch_state;
  logic [GAIN_W-1:0]         roll_gain;
  logic [GAIN_W-1:0]         pitch_gain;
  logic [STEP_W-1:0]         gyro_step_gain;
  logic                      pass;
  logic [CNT_W-1:0]          cnt;

  logic signed [AXIS_W-1:0]  ax_v, ay_v, az_v;
  logic signed [GN_W-1:0]    gn [2];
  logic [WIDE_W-1:0]         up, uq;
  logic signed [ACC_W-1:0]   ur;
  logic signed [WIDE_W-1:0]  prod, sqsum, bacc, bsum;
  logic signed [WIDE_W-1:0]  gterm [2];
  logic signed [ANGQ_W-1:0]  ang [2];
  logic                      czero, dneg;

  logic                      in_acc, calibrated, out_free;
  iter_req_t                 req;
  iter_rsp_t                 rsp;

  logic signed [AXIS_W-1:0]  zs, zoff;
  logic signed [WIDE_W-1:0]  cx0, cy0, gt, gmag, bv, bsat;
  logic [23:0]               dnum, drem;
  logic [15:0]               dq;
  logic signed [ACC_W-1:0]   ang_r;
  logic [GAIN_W-1:0]         gg;
  logic signed [ANG_W-1:0]   prev;

  assign cfg_ready  = 1'b1;
  assign in_acc     = in_valid && !in_stall;
  assign calibrated = (calib_count == CALC_W'(CAL_SAMPLES));
  assign out_free   = !out_valid || !out_stall;

  tcf_iter u_iter (
    .req(req),
    .rsp(rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_acc && calibrated) state_next = ST_ROLL_INIT;
      ST_ROLL_INIT:  state_next = ST_CORDIC;
      ST_CORDIC:     if (cnt == CNT_W'(CORDIC_ITERS - 1)) state_next = ST_CORDIC_END;
      ST_CORDIC_END: state_next = pass ? ST_GYRO_MUL : ST_SQ_Y;
      ST_SQ_Y:       state_next = ST_SQ_Z;
      ST_SQ_Z:       state_next = ST_SQRT_INIT;
      ST_SQRT_INIT:  state_next = ST_SQRT;
      ST_SQRT:       if (cnt == '0) state_next = ST_PITCH_INIT;
      ST_PITCH_INIT: state_next = ST_CORDIC;
      ST_GYRO_MUL:   state_next = ST_GYRO_SCALE;
      ST_GYRO_SCALE: begin
        priority if (ODD != 1) state_next = ST_GYRO_DIV;
        else state_next = pass ? ST_BLEND_PREV : ST_GYRO_MUL;
      end
      ST_GYRO_DIV:   if (cnt == CNT_W'(2 * DIV_DIGITS - 1)) state_next = ST_GYRO_END;
      ST_GYRO_END:   state_next = pass ? ST_BLEND_PREV : ST_GYRO_MUL;
      ST_BLEND_PREV: state_next = ST_BLEND_ACC;
      ST_BLEND_ACC:  state_next = ST_BLEND_SUM;
      ST_BLEND_SUM:  state_next = ST_BLEND_END;
      ST_BLEND_END:  state_next = pass ? ST_DONE : ST_BLEND_PREV;
      ST_DONE:       if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    gg       = (pass ? pitch_gain : roll_gain) > GAIN_ONE ? GAIN_ONE
                                                          : (pass ? pitch_gain : roll_gain);
    prev     = pass ? pitch_state : roll_state;
    req.p    = up;
    req.q    = uq;
    req.r    = ur;
    req.cnt  = cnt;
    req.op   = OP_HOLD;
    req.ma   = '0;
    req.mb   = '0;
    unique case (state)
      ST_CORDIC:     req.op = OP_CORDIC;
      ST_SQRT:       req.op = OP_SQRT;
      ST_GYRO_DIV: begin
        req.ma = $signed(OPND_W'(dnum));
        req.mb = OPND_W'(RECIP);
      end
      ST_SQ_Y: begin
        req.ma = OPND_W'(ay_v);
        req.mb = OPND_W'(ay_v);
      end
      ST_SQ_Z: begin
        req.ma = OPND_W'(az_v);
        req.mb = OPND_W'(az_v);
      end
      ST_GYRO_MUL: begin
        req.ma = OPND_W'(gn[pass]);
        req.mb = $signed(OPND_W'(gyro_step_gain));
      end
      ST_BLEND_PREV: begin
        req.ma = $signed(OPND_W'(gg));
        req.mb = OPND_W'(prev);
      end
      ST_BLEND_ACC: begin
        req.ma = $signed(OPND_W'(GAIN_ONE - gg));
        req.mb = OPND_W'(ang[pass]);
      end
      default: req.op = OP_HOLD;
    endcase
  end

  always_comb begin
    zs    = AXIS_W'(asum[2]);
    zoff  = zs[AXIS_W-1] ? -zs : zs;
    cx0   = (state == ST_PITCH_INIT) ? $signed(uq << 20) : -(WIDE_W'(az_v) <<< 20);
    cy0   = (state == ST_PITCH_INIT) ? (WIDE_W'(ax_v) <<< 30) : -(WIDE_W'(ay_v) <<< 20);
    ang_r = (ur + ACC_W'(128)) >>> 8;
    gt    = (prod + WIDE_W'(HALF_DIV)) >>> GSHIFT;
    gmag  = gt[WIDE_W-1] ? -gt : gt;
    // partial remainder and next 16-bit digit of the dividend
    dnum  = {up[7:0], uq[WIDE_W-1 -: 16]};
    dq    = prod[47:32];
    drem  = dnum - 24'({8'd0, dq} * 24'(ODD));
    bv    = (bsum >>> 16) + gterm[pass];
    if (bv > SAT_HI) begin
      bsat = SAT_HI;
    end else if (bv < SAT_LO) begin
      bsat = SAT_LO;
    end else begin
      bsat = bv;
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      calib_count    <= '0;
      asum[0]        <= '0;
      asum[1]        <= '0;
      asum[2]        <= '0;
      gsum[0]        <= '0;
      gsum[1]        <= '0;
      roll_state     <= '0;
      pitch_state    <= '0;
      roll_gain      <= GAIN_RESET;
      pitch_gain     <= GAIN_RESET;
      gyro_step_gain <= STEP_RESET;
      out_valid      <= 1'b0;
      pass           <= 1'b0;
      cnt            <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROLL_GAIN:  roll_gain      <= cfg_data[GAIN_W-1:0];
          CFG_PITCH_GAIN: pitch_gain     <= cfg_data[GAIN_W-1:0];
          CFG_STEP_GAIN:  gyro_step_gain <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && !calibrated) begin
        asum[0]     <= asum[0] + ASUM_W'(accel_x_raw >>> RAW_SHIFT);
        asum[1]     <= asum[1] + ASUM_W'(accel_y_raw >>> RAW_SHIFT);
        asum[2]     <= asum[2] + ASUM_W'(accel_z_raw >>> RAW_SHIFT);
        gsum[0]     <= gsum[0] + GSUM_W'(gyro_x_raw);
        gsum[1]     <= gsum[1] + GSUM_W'(gyro_y_raw);
        calib_count <= calib_count + 1'b1;
      end
      unique case (state)
        ST_ROLL_INIT:  begin pass <= 1'b0; cnt <= '0; end
        ST_PITCH_INIT: begin pass <= 1'b1; cnt <= '0; end
        ST_CORDIC:     cnt <= cnt + 1'b1;
        ST_CORDIC_END: if (pass) pass <= 1'b0;
        ST_SQRT_INIT:  cnt <= CNT_W'(SQRT_ITERS - 1);
        ST_SQRT:       cnt <= cnt - 1'b1;
        ST_GYRO_SCALE: begin
          cnt <= '0;
          if (ODD == 1) pass <= !pass;
        end
        ST_GYRO_DIV:   cnt <= cnt + 1'b1;
        ST_GYRO_END:   pass <= !pass;
        ST_BLEND_END: begin
          if (pass) pitch_state <= ANG_W'(bsat);
          else roll_state <= ANG_W'(bsat);
          pass <= !pass;
        end
        default: ;
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc && calibrated) begin
      ax_v  <= AXIS_W'(accel_x_raw >>> RAW_SHIFT) * AXIS_W'(CAL_SAMPLES) - AXIS_W'(asum[0]);
      ay_v  <= AXIS_W'(accel_y_raw >>> RAW_SHIFT) * AXIS_W'(CAL_SAMPLES) - AXIS_W'(asum[1]);
      az_v  <= AXIS_W'(accel_z_raw >>> RAW_SHIFT) * AXIS_W'(CAL_SAMPLES) - zoff;
      gn[0] <= GN_W'(gyro_x_raw) * GN_W'(CAL_SAMPLES) - GN_W'(gsum[0]);
      gn[1] <= GN_W'(gyro_y_raw) * GN_W'(CAL_SAMPLES) - GN_W'(gsum[1]);
    end
    unique case (state)
      ST_ROLL_INIT, ST_PITCH_INIT: begin
        czero <= (cx0 == '0) && (cy0 == '0);
        if (cx0[WIDE_W-1]) begin
          ur <= cy0[WIDE_W-1] ? -ANG_180 : ANG_180;
          up <= -cx0;
          uq <= -cy0;
        end else begin
          ur <= '0;
          up <= cx0;
          uq <= cy0;
        end
      end
      ST_CORDIC, ST_SQRT: begin
        up <= rsp.p;
        uq <= rsp.q;
        ur <= rsp.r;
      end
      ST_CORDIC_END: ang[pass] <= czero ? '0 : ANGQ_W'(ang_r);
      ST_SQ_Y:       prod <= rsp.prod;
      ST_SQ_Z: begin
        sqsum <= prod;
        prod  <= rsp.prod;
      end
      ST_SQRT_INIT: begin
        up <= WIDE_W'((sqsum + prod) <<< 20);
        uq <= '0;
      end
      ST_GYRO_MUL:   prod <= rsp.prod;
      ST_GYRO_SCALE: begin
        if (ODD == 1) begin
          gterm[pass] <= gt;
        end else begin
          dneg <= gt[WIDE_W-1];
          up   <= '0;
          uq   <= gmag;
        end
      end
      // even cycles multiply by the reciprocal, odd cycles take the digit and remainder
      ST_GYRO_DIV: begin
        if (!cnt[0]) begin
          prod <= rsp.prod;
        end else begin
          uq <= {uq[WIDE_W-17:0], dq};
          up <= WIDE_W'(drem[7:0]);
        end
      end
      ST_GYRO_END: gterm[pass] <= dneg ? -($signed(uq) + WIDE_W'(up != '0)) : $signed(uq);
      ST_BLEND_PREV: prod <= rsp.prod;
      ST_BLEND_ACC: begin
        bacc <= prod;
        prod <= rsp.prod;
      end
      ST_BLEND_SUM: bsum <= bacc + prod + WIDE_W'(32768);
      ST_DONE: begin
        if (out_free) begin
          roll_angle  <= roll_state;
          pitch_angle <= pitch_state;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/tcf_checker.sv
// Port-level checks for the tilt complementary filter, bound to the top level.
// Depends on tcf_pkg and tilt_complementary_filter.
module tcf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [tcf_pkg::ANG_W-1:0] roll_angle,
  input logic signed [tcf_pkg::ANG_W-1:0] pitch_angle
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(roll_angle) && $stable(pitch_angle))
    else $error("stalled result changed");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a busy period");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid)
    else $error("busy period ended without a result");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .roll_angle  (roll_angle),
  .pitch_angle (pitch_angle)
);
